@@ sv/gbe_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gbe_pkg
// Shared types and constants for the gap buffer line editor.
// ============================================================================
package gbe_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam int FUNC_W = 2;
  localparam int POS_W  = 9;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 9;
  localparam int STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT    = 2'd0,
    FN_BACKSPACE = 2'd1,
    FN_READ      = 2'd2,
    FN_CLEAR     = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_COMMIT,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic judge;
    logic rd_issue;
    logic step;
    logic commit;
    logic clear;
    logic respond;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  ok;
    logic  need_move;
    logic  at_pos;
  } sts_t;

endpackage

@@ sv/gap_buffer_line_editor_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gap_buffer_line_editor_top
// One line of text held as a gap buffer, edited by insert, backspace, read
// and clear operations at a logical cursor position.
// ============================================================================
//
// Channel   Ports                                       Transfer
// --------  ------------------------------------------  --------------------------
// input     start, busy, in_func, in_position,          start high while busy low
//           in_char_in
// result    out_valid, out_char_out, out_line_length,   out_valid high, one cycle
//           out_status
//
// An insert or backspace that changes the line keeps busy high while the gap
// moves from the current gap start to the position; the gap moves one
// character per cycle through the single write port of the text memory.
// Every other item, a backspace at position zero included, skips the gap
// move. The result strobe comes in the first cycle with busy low, and a new
// item may be accepted in that same cycle. Reset (synchronous, active low)
// empties the line at once; the text memory itself is not cleared, since
// only written bytes are ever read back.
// The receiver cannot stall, so no result waits.
//
module gap_buffer_line_editor_top #(
  parameter int CAPACITY = gbe_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [gbe_pkg::FUNC_W-1:0]  in_func,
  input  logic [gbe_pkg::POS_W-1:0]   in_position,
  input  logic [gbe_pkg::CHAR_W-1:0]  in_char_in,
  output logic                        out_valid,
  output logic [gbe_pkg::CHAR_W-1:0]  out_char_out,
  output logic [gbe_pkg::LEN_W-1:0]   out_line_length,
  output logic [gbe_pkg::STAT_W-1:0]  out_status
);
  import gbe_pkg::*;

  // The controller only sequences; all state of the line lives in the datapath.
  cmd_t cmd;
  sts_t sts;

  gbe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath captures the item when it is accepted, judges it against the
  // line length, walks the gap, commits the edit and registers the result.
  gbe_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_char_out    (out_char_out),
    .out_line_length (out_line_length),
    .out_status      (out_status)
  );

endmodule

@@ sv/gbe_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gbe_ctrl
// Controller state machine: sequences decode, gap moves, commit and response.
// ============================================================================
module gbe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  gbe_pkg::sts_t sts,
  output gbe_pkg::cmd_t cmd
);
  import gbe_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.judge = 1'b1;
        if (sts.func == FN_CLEAR) begin
          cmd.clear = 1'b1;
        end
        if (sts.func == FN_READ && sts.ok) begin
          cmd.rd_issue = 1'b1;
        end
        state_nxt = sts.need_move ? S_MOVE : S_RESP;
      end
      S_MOVE: begin
        // The cycle that finds the gap in place also drains the last copy.
        if (sts.at_pos) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ sv/gbe_dpath.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gbe_dpath
// Datapath: item registers, gap pointers, text memory and result registers.
// ============================================================================
module gbe_dpath #(
  parameter int CAPACITY = gbe_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gbe_pkg::cmd_t               cmd,
  output gbe_pkg::sts_t               sts,
  input  logic [gbe_pkg::FUNC_W-1:0]  in_func,
  input  logic [gbe_pkg::POS_W-1:0]   in_position,
  input  logic [gbe_pkg::CHAR_W-1:0]  in_char_in,
  output logic                        out_valid,
  output logic [gbe_pkg::CHAR_W-1:0]  out_char_out,
  output logic [gbe_pkg::LEN_W-1:0]   out_line_length,
  output logic [gbe_pkg::STAT_W-1:0]  out_status
);
  import gbe_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = (CW > POS_W) ? CW : POS_W;

  // Item registers.
  func_t             func_r;
  logic [POS_W-1:0]  pos_r;
  logic [CHAR_W-1:0] char_r;
  status_t           stat_r;
  status_t           stat_nxt;

  // Gap pointers.
  logic [CW-1:0] gs_r;
  logic [CW-1:0] gl_r;
  logic [CW-1:0] len;

  // Text memory and its ports.
  logic [CHAR_W-1:0] mem [CAPACITY];
  logic [CHAR_W-1:0] rd_data_r;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic              mv_pend_r;
  logic [AW-1:0]     mv_waddr_r;
  logic [AW-1:0]     step_waddr;

  // Result registers.
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic [LEN_W-1:0]  out_len_r;
  status_t           out_stat_r;

  logic [LW-1:0] pos_x;
  logic [LW-1:0] len_x;
  logic [LW-1:0] gs_x;
  logic [LW-1:0] gl_x;
  logic          gt_len;
  logic          ge_len;
  logic          go_left;

  assign len     = CW'(CAPACITY) - gl_r;
  assign pos_x   = LW'(pos_r);
  assign len_x   = LW'(len);
  assign gs_x    = LW'(gs_r);
  assign gl_x    = LW'(gl_r);
  assign gt_len  = (pos_x > len_x);
  assign ge_len  = (pos_x >= len_x);
  assign go_left = (pos_x < gs_x);

  always_comb begin
    stat_nxt = ST_OK;
    unique case (func_r)
      FN_INSERT: begin
        if (gt_len) begin
          stat_nxt = ST_RANGE;
        end else if (gl_r == '0) begin
          stat_nxt = ST_FULL;
        end
      end
      FN_BACKSPACE: begin
        if (pos_r != '0 && gt_len) begin
          stat_nxt = ST_RANGE;
        end
      end
      FN_READ: begin
        if (ge_len) begin
          stat_nxt = ST_RANGE;
        end
      end
      default: begin
        stat_nxt = ST_OK;
      end
    endcase
  end

  always_comb begin
    sts.func      = func_r;
    sts.ok        = (stat_nxt == ST_OK);
    sts.need_move = (stat_nxt == ST_OK) &&
                    ((func_r == FN_INSERT) ||
                     (func_r == FN_BACKSPACE && pos_r != '0));
    sts.at_pos    = (pos_x == gs_x);
  end

  // A left step copies the byte before the gap to the gap's top end; a right
  // step copies the byte after the gap to the gap's bottom end.
  assign step_waddr = go_left ? AW'(gs_r + gl_r - 1'b1) : AW'(gs_r);

  always_comb begin
    rd_en = cmd.step | cmd.rd_issue;
    if (cmd.step) begin
      rd_addr = go_left ? AW'(gs_r - 1'b1) : AW'(gs_r + gl_r);
    end else begin
      rd_addr = go_left ? AW'(pos_x) : AW'(pos_x + gl_x);
    end
    wr_en   = mv_pend_r | (cmd.commit && func_r == FN_INSERT);
    wr_addr = mv_pend_r ? mv_waddr_r : AW'(gs_r);
    wr_data = mv_pend_r ? rd_data_r : char_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r        <= '0;
      gl_r        <= CW'(CAPACITY);
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mv_pend_r   <= cmd.step;
      out_valid_r <= cmd.respond;
      if (cmd.clear) begin
        gs_r <= '0;
        gl_r <= CW'(CAPACITY);
      end else if (cmd.step) begin
        gs_r <= go_left ? gs_r - 1'b1 : gs_r + 1'b1;
      end else if (cmd.commit) begin
        if (func_r == FN_INSERT) begin
          gs_r <= gs_r + 1'b1;
          gl_r <= gl_r - 1'b1;
        end else begin
          gs_r <= gs_r - 1'b1;
          gl_r <= gl_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      mv_waddr_r <= step_waddr;
    end
    if (cmd.load) begin
      func_r <= func_t'(in_func);
      pos_r  <= in_position;
      char_r <= in_char_in;
    end
    if (cmd.judge) begin
      stat_r <= stat_nxt;
    end
    if (cmd.respond) begin
      out_char_r <= (func_r == FN_READ && stat_r == ST_OK) ? rd_data_r : '0;
      out_len_r  <= LEN_W'(len);
      out_stat_r <= stat_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = out_char_r;
  assign out_line_length = out_len_r;
  assign out_status      = out_stat_r;

endmodule

@@ sv/gbe_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gbe_checker
// Port-level checks on the gap buffer line editor, bound to the top level.
// ============================================================================
module gbe_checker #(
  parameter int CAPACITY = gbe_pkg::CAPACITY_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [gbe_pkg::CHAR_W-1:0]  out_char_out,
  input logic [gbe_pkg::LEN_W-1:0]   out_line_length,
  input logic [gbe_pkg::STAT_W-1:0]  out_status
);
  import gbe_pkg::*;

  // An accepted item holds off the next one.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but busy did not rise");

  // Results never come back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // A refused operation returns no character.
  a_refused_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_char_out == '0))
    else $error("refused operation returned a character");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL ||
                   out_status == ST_RANGE))
    else $error("undefined status code");

  // The line never grows past the store.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_line_length) <= CAPACITY))
    else $error("line length beyond capacity");

endmodule

bind gap_buffer_line_editor_top gbe_checker #(
  .CAPACITY (CAPACITY)
) u_gbe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_char_out    (out_char_out),
  .out_line_length (out_line_length),
  .out_status      (out_status)
);
